### rtl/core/pts_pkg.sv
// Shared types, constants and helper functions for the packed upper-triangular store.
// Used by pts_front, pts_queue, pts_back and packed_upper_triangular_store.
// No dependencies.
package pts_pkg;

    // Field widths fixed by the item format
    localparam int DATA_W      = 32;
    localparam int ORDER_W     = 5;
    localparam int INDEX_W     = 4;
    localparam int CMD_W       = 2;
    localparam int COUNT_W     = 8;
    localparam int CFG_INDEX_W = 1;

    // Width of the held order: reaches the largest supported order of 64
    localparam int ORDER_REG_W = 7;

    // Width of slot arithmetic: covers n*(n+1) for an order of up to 64
    localparam int CALC_W = 13;

    // Default largest matrix order
    localparam int DEFAULT_MAX_ORDER = 16;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Saturation value of the count result
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Command codes
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COUNT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MATRIX_ORDER = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FILL_VALUE   = 1'd1;

    // One command item
    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic [INDEX_W-1:0]        row;
        logic [INDEX_W-1:0]        col;
        logic signed [DATA_W-1:0]  write_value;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic signed [DATA_W-1:0]  read_value;
        logic [COUNT_W-1:0]        nondefault_count;
        logic                      index_error;
    } out_item_t;

    // Classified job handed from front to back
    typedef enum logic [2:0] {
        JOB_READ   = 3'd0,
        JOB_WRITE  = 3'd1,
        JOB_FILL   = 3'd2,
        JOB_COUNT  = 3'd3,
        JOB_REJECT = 3'd4
    } job_kind_t;

    typedef struct packed {
        job_kind_t                 kind;
        logic signed [DATA_W-1:0]  write_value;
    } job_t;

    // Number of packed words for a given largest order
    function automatic int store_depth(input int max_order);
        return max_order * (max_order + 1) / 2;
    endfunction

    // Address width of the packed store
    function automatic int slot_w(input int max_order);
        return (store_depth(max_order) > 1) ? $clog2(store_depth(max_order)) : 1;
    endfunction

endpackage

### rtl/core/pts_queue.sv
// Short FIFO of classified jobs between the front and back parts.
// Depends on pts_pkg for the queue depth constants.
module pts_queue #(
    parameter int WIDTH = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    import pts_pkg::*;

    logic [WIDTH-1:0]       entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] fill_reg;

    assign full     = (fill_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Store an entry on push
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/core/pts_front.sv
// Front part: clamps the order, checks indices, classifies the command and
// computes the packed slot (or the last slot for a count). Depends on pts_pkg.
module pts_front #(
    parameter int MAX_ORDER = pts_pkg::DEFAULT_MAX_ORDER
) (
    input  pts_pkg::in_item_t                       item,
    input  logic [pts_pkg::ORDER_REG_W-1:0]         order,
    output pts_pkg::job_t                           job,
    output logic [pts_pkg::slot_w(MAX_ORDER)-1:0]   slot
);
    import pts_pkg::*;

    localparam int SLOT_W = slot_w(MAX_ORDER);
    localparam logic [ORDER_REG_W-1:0] ORDER_CAP = ORDER_REG_W'(MAX_ORDER);

    logic [ORDER_REG_W-1:0] n_eff;
    logic [CALC_W-1:0]  n_w;
    logic [CALC_W-1:0]  r_w;
    logic [CALC_W-1:0]  c_w;
    logic [CALC_W-1:0]  row_base;
    logic [CALC_W-1:0]  row_skip;
    logic [CALC_W-1:0]  elem_slot;
    logic [CALC_W-1:0]  last_slot;
    logic               in_range;
    logic               below_diag;

    // Clamp the configured order into 1..cap
    always_comb
    begin
        if (order == '0)
        begin
            n_eff = ORDER_REG_W'(1);
        end
        else if (order > ORDER_CAP)
        begin
            n_eff = ORDER_CAP;
        end
        else
        begin
            n_eff = order;
        end
    end

    // Packed slot: row*n - row*(row-1)/2 + (col-row)
    always_comb
    begin
        n_w       = CALC_W'(n_eff);
        r_w       = CALC_W'(item.row);
        c_w       = CALC_W'(item.col);
        row_base  = r_w * n_w;
        row_skip  = (r_w * (r_w - 1'b1)) >> 1;
        elem_slot = row_base - row_skip + c_w - r_w;
        last_slot = ((n_w * (n_w + 1'b1)) >> 1) - 1'b1;
    end

    assign in_range   = (ORDER_REG_W'(item.row) < n_eff) && (ORDER_REG_W'(item.col) < n_eff);
    assign below_diag = (item.row > item.col);

    // Classify the command
    always_comb
    begin
        job.write_value = item.write_value;
        slot            = elem_slot[SLOT_W-1:0];
        case (item.cmd)
            CMD_READ:
            begin
                if (!in_range)
                begin
                    job.kind = JOB_REJECT;
                end
                else if (below_diag)
                begin
                    job.kind = JOB_FILL;
                end
                else
                begin
                    job.kind = JOB_READ;
                end
            end
            CMD_WRITE:
            begin
                job.kind = (!in_range || below_diag) ? JOB_REJECT : JOB_WRITE;
            end
            CMD_COUNT:
            begin
                job.kind = JOB_COUNT;
                slot     = last_slot[SLOT_W-1:0];
            end
            default:
            begin
                job.kind = JOB_REJECT;
            end
        endcase
    end

endmodule

### rtl/core/pts_back.sv
// Back part: owns the packed store, runs the clearing pass after reset, and
// carries out read, write and count jobs. Depends on pts_pkg.
module pts_back #(
    parameter int MAX_ORDER = pts_pkg::DEFAULT_MAX_ORDER
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    q_empty,
    input  pts_pkg::job_t                           q_job,
    input  logic [pts_pkg::slot_w(MAX_ORDER)-1:0]   q_slot,
    output logic                                    q_pop,
    input  logic signed [pts_pkg::DATA_W-1:0]       fill_value,
    output pts_pkg::out_item_t                      result,
    output logic                                    done,
    output logic                                    clearing
);
    import pts_pkg::*;

    localparam int DEPTH  = store_depth(MAX_ORDER);
    localparam int SLOT_W = slot_w(MAX_ORDER);
    localparam logic [SLOT_W-1:0] LAST_ENTRY = SLOT_W'(DEPTH - 1);

    typedef enum logic [4:0] {
        B_CLEAR = 5'b00001,
        B_IDLE  = 5'b00010,
        B_READ  = 5'b00100,
        B_SCAN  = 5'b01000,
        B_DRAIN = 5'b10000
    } back_state_t;

    back_state_t         state_reg,  state_next;
    logic [SLOT_W-1:0]   addr_reg,   addr_next;
    logic                pend_reg,   pend_next;
    logic                done_reg,   done_next;
    logic [SLOT_W-1:0]   last_reg,   last_next;
    logic [COUNT_W-1:0]  cnt_reg,    cnt_next;
    out_item_t           result_reg, result_next;

    logic [DATA_W-1:0]   mem [DEPTH];
    logic [DATA_W-1:0]   rd_q;
    logic [SLOT_W-1:0]   mem_addr;
    logic                mem_we;
    logic [DATA_W-1:0]   mem_wdata;
    logic                hit;
    logic [COUNT_W-1:0]  cnt_plus;

    // Packed store: one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_q <= mem[mem_addr];
    end

    assign q_pop = (state_reg == B_IDLE) && !q_empty;

    // Select the store access for this cycle
    always_comb
    begin
        mem_addr  = q_slot;
        mem_we    = 1'b0;
        mem_wdata = q_job.write_value;
        if ((state_reg == B_CLEAR) || (state_reg == B_SCAN))
        begin
            mem_addr = addr_reg;
        end
        if (state_reg == B_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_wdata = '0;
        end
        else if (q_pop && (q_job.kind == JOB_WRITE))
        begin
            mem_we = 1'b1;
        end
    end

    // Count step: add a word that differs from the fill value, saturating
    assign hit      = (rd_q != fill_value);
    assign cnt_plus = (pend_reg && hit && (cnt_reg != COUNT_MAX)) ? cnt_reg + 1'b1 : cnt_reg;

    // Sequence jobs
    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        pend_next   = pend_reg;
        last_next   = last_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            B_CLEAR:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_ENTRY)
                begin
                    addr_next  = '0;
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_pop)
                begin
                    result_next = '0;
                    case (q_job.kind)
                        JOB_READ:
                        begin
                            state_next = B_READ;
                        end
                        JOB_WRITE:
                        begin
                            done_next = 1'b1;
                        end
                        JOB_FILL:
                        begin
                            result_next.read_value = fill_value;
                            done_next              = 1'b1;
                        end
                        JOB_COUNT:
                        begin
                            addr_next  = '0;
                            last_next  = q_slot;
                            cnt_next   = '0;
                            pend_next  = 1'b0;
                            state_next = B_SCAN;
                        end
                        default:
                        begin
                            result_next.index_error = 1'b1;
                            done_next               = 1'b1;
                        end
                    endcase
                end
            end
            B_READ:
            begin
                result_next            = '0;
                result_next.read_value = rd_q;
                done_next              = 1'b1;
                state_next             = B_IDLE;
            end
            B_SCAN:
            begin
                cnt_next  = cnt_plus;
                pend_next = 1'b1;
                if (addr_reg == last_reg)
                begin
                    state_next = B_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            B_DRAIN:
            begin
                result_next                  = '0;
                result_next.nondefault_count = cnt_plus;
                pend_next                    = 1'b0;
                done_next                    = 1'b1;
                state_next                   = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            addr_reg  <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        last_reg   <= last_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    assign result   = result_reg;
    assign done     = done_reg;
    assign clearing = (state_reg == B_CLEAR);

endmodule

### rtl/core/packed_upper_triangular_store.sv
// Top level of the packed upper-triangular matrix store: configuration
// registers, front classifier, job queue and back executor.
// Depends on pts_pkg, pts_front, pts_queue and pts_back.
//
//   Channel   Signals                         Transfer when
//   --------  ------------------------------  ----------------------------------
//   command   start, busy, item               start high and busy low at clk edge
//   result    done, result                    done high (one cycle, no backpressure)
//   config    cfg_we, cfg_index, cfg_data     cfg_we high at clk edge
//
// After reset the store is cleared one word a cycle, MAX_ORDER*(MAX_ORDER+1)/2
// words (136 at the default order of 16); busy stays high during the pass.
// The single store port sets the pace: a read passes through B_READ in the back
// part, a write, below-diagonal read or rejected command ends when popped, and a
// count scans the n*(n+1)/2 words of order n in B_SCAN, then B_DRAIN.
// The front accepts while the 2-entry job queue has room; busy rises when it
// is full and during the clearing pass. Results are registered and cannot be stalled.
module packed_upper_triangular_store #(
    parameter int MAX_ORDER = pts_pkg::DEFAULT_MAX_ORDER
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  pts_pkg::in_item_t                   item,
    output logic                                done,
    output pts_pkg::out_item_t                  result,
    input  logic                                cfg_we,
    input  logic [pts_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pts_pkg::DATA_W-1:0]          cfg_data
);
    import pts_pkg::*;

    localparam int SLOT_W = slot_w(MAX_ORDER);
    localparam int QW     = $bits(job_t) + SLOT_W;

    logic [ORDER_REG_W-1:0]    order_reg;
    logic signed [DATA_W-1:0]  fill_reg;

    job_t                f_job;
    logic [SLOT_W-1:0]   f_slot;
    logic [QW-1:0]       q_out;
    logic                q_full;
    logic                q_empty;
    logic                q_pop;
    logic                push;
    logic                clearing;
    job_t                b_job;
    logic [SLOT_W-1:0]   b_slot;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_REG_W'(MAX_ORDER);
            fill_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MATRIX_ORDER: order_reg <= ORDER_REG_W'(cfg_data[ORDER_W-1:0]);
                REG_FILL_VALUE:   fill_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Accept while the queue has room and the clearing pass is over
    assign busy = clearing || q_full;
    assign push = start && !busy;

    pts_front #(
        .MAX_ORDER (MAX_ORDER)
    ) u_front (
        .item  (item),
        .order (order_reg),
        .job   (f_job),
        .slot  (f_slot)
    );

    pts_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({f_job, f_slot}),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign b_job  = job_t'(q_out[QW-1:SLOT_W]);
    assign b_slot = q_out[SLOT_W-1:0];

    pts_back #(
        .MAX_ORDER (MAX_ORDER)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_job      (b_job),
        .q_slot     (b_slot),
        .q_pop      (q_pop),
        .fill_value (fill_reg),
        .result     (result),
        .done       (done),
        .clearing   (clearing)
    );

endmodule

### bench/tb_packed_upper_triangular_store.sv
// Self-checking bench for packed_upper_triangular_store: directed and random
// read/write/count commands across several order and fill settings.
// Depends on pts_pkg and the packed_upper_triangular_store RTL.
`timescale 1ns / 1ps

module tb_packed_upper_triangular_store;
    import pts_pkg::*;

    localparam int ORDER_LIMIT = DEFAULT_MAX_ORDER;
    localparam int STORE_WORDS = ORDER_LIMIT * (ORDER_LIMIT + 1) / 2;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 100;

    // Mirror of the store and registers; keeps the outcomes still to arrive
    class store_scoreboard;
        logic [DATA_W-1:0]  words [STORE_WORDS];
        logic [ORDER_W-1:0] order_reg;
        logic [DATA_W-1:0]  fill_reg;
        out_item_t          pending_outcomes [$];
        int                 mismatches;

        function void clear();
            foreach (words[i]) words[i] = '0;
            order_reg = ORDER_W'(ORDER_LIMIT);
            fill_reg = '0;
            pending_outcomes.delete();
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
            if (idx == REG_MATRIX_ORDER)
                order_reg = data[ORDER_W-1:0];
            else
                fill_reg = data;
        endfunction

        // Clamp the order register into 1..ORDER_LIMIT
        function int order_in_use();
            if (order_reg == 0)
                return 1;
            if (order_reg > ORDER_LIMIT)
                return ORDER_LIMIT;
            return int'(order_reg);
        endfunction

        function int slot(int n, int r, int c);
            return (r * n - r * (r - 1) / 2 + (c - r)) % STORE_WORDS;
        endfunction

        // Work out the outcome of one accepted command and update the mirror
        function void note_command(in_item_t it);
            out_item_t outcome;
            int n;
            int r;
            int c;
            int hits;
            bit in_range;
            n = order_in_use();
            r = it.row;
            c = it.col;
            in_range = (r < n) && (c < n);
            outcome = '0;
            case (it.cmd)
                CMD_READ:
                begin
                    if (!in_range)
                        outcome.index_error = 1'b1;
                    else if (r > c)
                        outcome.read_value = fill_reg;
                    else
                        outcome.read_value = words[slot(n, r, c)];
                end
                CMD_WRITE:
                begin
                    if (!in_range || r > c)
                        outcome.index_error = 1'b1;
                    else
                        words[slot(n, r, c)] = it.write_value;
                end
                CMD_COUNT:
                begin
                    hits = 0;
                    for (int i = 0; i < n; i++)
                        for (int j = i; j < n; j++)
                            if (words[slot(n, i, j)] !== fill_reg)
                                hits++;
                    outcome.nondefault_count = (hits > 255) ? COUNT_MAX : COUNT_W'(hits);
                end
                default:
                    outcome.index_error = 1'b1;
            endcase
            pending_outcomes.push_back(outcome);
        endfunction

        // Compare one result transfer with the oldest outcome
        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result read_value %0d count %0d error %0b",
                         $time, got.read_value, got.nondefault_count, got.index_error);
                mismatches++;
                return;
            end
            want = pending_outcomes.pop_front();
            if (got.read_value !== want.read_value)
            begin
                $display("%0t: read_value expected %0d actual %0d",
                         $time, want.read_value, got.read_value);
                mismatches++;
            end
            if (got.nondefault_count !== want.nondefault_count)
            begin
                $display("%0t: nondefault_count expected %0d actual %0d",
                         $time, want.nondefault_count, got.nondefault_count);
                mismatches++;
            end
            if (got.index_error !== want.index_error)
            begin
                $display("%0t: index_error expected %0b actual %0b",
                         $time, want.index_error, got.index_error);
                mismatches++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    in_item_t               item;
    logic                   done;
    out_item_t              result;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DATA_W-1:0]      cfg_data;

    store_scoreboard sb;
    int              cycle_count;
    int              max_gap;

    packed_upper_triangular_store u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock: 2 ns period
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_result(result);
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Idle a random number of cycles, then hold the command until it transfers
    task automatic send_command(in_item_t it);
        int gap;
        gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.note_command(it);
    endtask

    task automatic issue(logic [CMD_W-1:0] cmd, int row, int col, logic [DATA_W-1:0] value);
        in_item_t it;
        it.cmd = cmd;
        it.row = INDEX_W'(row);
        it.col = INDEX_W'(col);
        it.write_value = value;
        send_command(it);
    endtask

    // Drop start and wait for every outstanding result
    task automatic drain();
        start <= 1'b0;
        while (sb.pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic program_regs(logic [DATA_W-1:0] order_data, logic [DATA_W-1:0] fill_data);
        cfg_we <= 1'b1;
        cfg_index <= REG_MATRIX_ORDER;
        cfg_data <= order_data;
        @(posedge clk);
        sb.write_reg(REG_MATRIX_ORDER, order_data);
        cfg_index <= REG_FILL_VALUE;
        cfg_data <= fill_data;
        @(posedge clk);
        sb.write_reg(REG_FILL_VALUE, fill_data);
        cfg_we <= 1'b0;
    endtask

    // Mostly in-range commands, writes mostly on or above the diagonal
    function automatic in_item_t random_command();
        in_item_t it;
        int n;
        int p;
        int r;
        int c;
        int tmp;
        n = sb.order_in_use();
        p = $urandom_range(0, 99);
        if (p < 40)
            it.cmd = CMD_READ;
        else if (p < 82)
            it.cmd = CMD_WRITE;
        else if (p < 91)
            it.cmd = CMD_COUNT;
        else
            it.cmd = CMD_UNUSED;
        if ($urandom_range(0, 9) < 8)
        begin
            r = $urandom_range(0, n - 1);
            c = $urandom_range(0, n - 1);
            if (it.cmd == CMD_WRITE && r > c && $urandom_range(0, 3) != 0)
            begin
                tmp = r;
                r = c;
                c = tmp;
            end
        end
        else
        begin
            r = $urandom_range(0, 15);
            c = $urandom_range(0, 15);
        end
        it.row = INDEX_W'(r);
        it.col = INDEX_W'(c);
        case ($urandom_range(0, 7))
            0: it.write_value = sb.fill_reg;
            1: it.write_value = 32'h7FFF_FFFF;
            2: it.write_value = 32'h8000_0000;
            3: it.write_value = DATA_W'($urandom_range(0, 3));
            default: it.write_value = $urandom();
        endcase
        return it;
    endfunction

    initial
    begin
        logic [ORDER_W-1:0] order_pick;
        logic [DATA_W-1:0]  fill_pick;
        sb = new();
        sb.clear();
        cycle_count = 0;
        max_gap = 3;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Let the clearing pass finish
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);

        // Reset settings: extremes of the data and indices
        issue(CMD_WRITE, 0, 0, 32'h7FFF_FFFF);
        issue(CMD_WRITE, 0, 15, 32'h8000_0000);
        issue(CMD_WRITE, 15, 15, 32'hFFFF_FFFF);
        issue(CMD_WRITE, 9, 4, 32'h0000_1234);
        issue(CMD_READ, 0, 0, 32'h0);
        issue(CMD_READ, 0, 15, 32'h0);
        issue(CMD_READ, 15, 15, 32'h0);
        issue(CMD_READ, 15, 0, 32'h0);
        issue(CMD_COUNT, 0, 0, 32'h0);
        issue(CMD_UNUSED, 15, 15, 32'hFFFF_FFFF);

        // Small order: out-of-range indices, fill value, old data through new layout
        drain();
        program_regs(32'd4, 32'h7FFF_FFFF);
        issue(CMD_READ, 4, 0, 32'h0);
        issue(CMD_READ, 0, 4, 32'h0);
        issue(CMD_WRITE, 3, 15, 32'h5555_AAAA);
        issue(CMD_READ, 2, 1, 32'h0);
        issue(CMD_WRITE, 3, 3, 32'h7FFF_FFFF);
        issue(CMD_READ, 1, 1, 32'h0);
        issue(CMD_COUNT, 0, 0, 32'h0);

        // Order register zero acts as one
        drain();
        program_regs(32'hFFFF_FFE0, 32'h8000_0000);
        issue(CMD_READ, 0, 0, 32'h0);
        issue(CMD_READ, 0, 1, 32'h0);
        issue(CMD_COUNT, 0, 0, 32'h0);

        // Order register above the limit acts as the limit
        drain();
        program_regs(32'd31, 32'h0);
        issue(CMD_COUNT, 0, 0, 32'h0);
        issue(CMD_READ, 15, 15, 32'h0);

        // Random phases, each with fresh register settings
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            case ($urandom_range(0, 5))
                0: order_pick = 5'd1;
                1: order_pick = 5'd16;
                2: order_pick = 5'd0;
                3: order_pick = ORDER_W'($urandom_range(17, 31));
                default: order_pick = ORDER_W'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 5))
                0: fill_pick = 32'h0;
                1: fill_pick = 32'h8000_0000;
                2: fill_pick = 32'h7FFF_FFFF;
                3: fill_pick = sb.words[$urandom_range(0, STORE_WORDS - 1)];
                default: fill_pick = $urandom();
            endcase
            program_regs({(DATA_W - ORDER_W)'($urandom()), order_pick}, fill_pick);
            repeat (ITEMS_PER_PHASE) send_command(random_command());
        end

        drain();
        repeat (4) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_outcomes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
